// File: hw/rtl/infix_to_postfix_converter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define IPC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IPC_ASSERT(label, ante, cons, msg)
`define IPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Character codes, token classes and operator priorities.
// ----------------------------------------------------------------------------
package ipc_pkg;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_Z      = 8'h5A;

	typedef enum logic [1:0] {
		TK_LETTER,
		TK_LPAREN,
		TK_RPAREN,
		TK_OPER
	} tok_class_t;

	// priority offset by one: unknown 0, '(' 1, '+' '-' 2, '*' '/' 3
	typedef logic [1:0] prio_t;

	function automatic prio_t prio_of(logic [7:0] c);
		prio_t p;
		case (c)
			CH_STAR, CH_SLASH: p = 2'd3;
			CH_PLUS, CH_MINUS: p = 2'd2;
			CH_LPAREN:         p = 2'd1;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic tok_class_t classify(logic [7:0] c);
		tok_class_t k;
		if (c >= CH_A && c <= CH_Z) begin
			k = TK_LETTER;
		end else if (c == CH_LPAREN) begin
			k = TK_LPAREN;
		end else if (c == CH_RPAREN) begin
			k = TK_RPAREN;
		end else begin
			k = TK_OPER;
		end
		return k;
	endfunction

endpackage

// File: hw/rtl/ipc_ram.sv
// ----------------------------------------------------------------------------
// ipc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix conversion, one character per input item,
// with the operator stack held in a RAM.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tdata            tlast         tuser
// s_*      in   token[7:0]       last_token    -
// m_*      out  out_char[7:0]    last_of_run   {overflow, expression_end}
//
// Flow: an item is handled in ST_RUN, one emitted stack entry at a time (a discarded
//   '(' is popped as the item ends); a last item also empties the stack in ST_FLUSH.
//   The pop loop is set by the stack RAM read port: one entry per cycle, unless stalled.
// Items are taken one at a time; s_tready is high only between items.
// Reset (arst_n low) empties the stack and clears the overflow flag; the
//   RAM itself is not cleared.
// A stall on m_tready holds the pop loop once the output register and the
//   one-entry hold stage are both full.
//
`include "infix_to_postfix_converter_unit_defines.svh"

module infix_to_postfix_converter_unit
	import ipc_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] token
	input  logic       s_tlast,   // last_token

	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast,   // last_of_run
	output logic [1:0] m_tuser    // [0] expression_end, [1] overflow
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	state_t     state_q, state_d;
	logic [7:0] tok_q;
	logic       last_q;
	tok_class_t cls_q;
	prio_t      prio_q;

	// stack: count, cached top, and a flag that the top sits on the RAM output
	logic [CW-1:0] count_q;
	logic [7:0]    top_q;
	logic          top_ram_q;
	logic          ovf_q;

	// one-entry hold stage: a result waits here until we know whether
	// it closes the run
	logic       pend_valid_q;
	logic [7:0] pend_char_q;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       out_end_q;
	logic       out_ovf_q;

	logic [7:0] rd_data;
	logic [7:0] top;
	logic       nonempty, full, out_free, can_emit;
	logic       pop_en, emit_en, push_req, push_en, ovf_set, fin_move, rd_en;
	logic       out_load;
	logic [7:0] emit_char;

	assign top      = top_ram_q ? rd_data : top_q;
	assign nonempty = (count_q != '0);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign out_free = !out_valid_q || m_tready;
	assign can_emit = !pend_valid_q || out_free;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		pop_en   = 1'b0;
		emit_en  = 1'b0;
		push_req = 1'b0;
		fin_move = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				unique case (cls_q)
					TK_LETTER: begin
						if (can_emit) begin
							emit_en = 1'b1;
							state_d = last_q ? ST_FLUSH : ST_FINISH;
						end
					end
					TK_LPAREN: begin
						push_req = 1'b1;
						state_d  = last_q ? ST_FLUSH : ST_FINISH;
					end
					TK_RPAREN: begin
						if (nonempty && top != CH_LPAREN) begin
							if (can_emit) begin
								pop_en  = 1'b1;
								emit_en = 1'b1;
							end
						end else begin
							// drop the matching '(' if there is one
							pop_en  = nonempty;
							state_d = last_q ? ST_FLUSH : ST_FINISH;
						end
					end
					TK_OPER: begin
						if (nonempty && prio_of(top) >= prio_q) begin
							if (can_emit) begin
								pop_en  = 1'b1;
								emit_en = 1'b1;
							end
						end else begin
							push_req = 1'b1;
							state_d  = last_q ? ST_FLUSH : ST_FINISH;
						end
					end
				endcase
			end
			ST_FLUSH: begin
				if (nonempty) begin
					if (can_emit) begin
						pop_en  = 1'b1;
						emit_en = 1'b1;
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!pend_valid_q || out_free) begin
					fin_move = pend_valid_q;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	assign emit_char = pop_en ? top : tok_q;
	assign push_en   = push_req && !full;
	assign ovf_set   = push_req && full;
	assign rd_en     = pop_en && (count_q >= CW'(2));
	assign out_load  = (emit_en && pend_valid_q) || fin_move;

	ipc_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (push_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(tok_q),
		.rd_en  (rd_en),
		.rd_addr(AW'(count_q - CW'(2))),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tok_q        <= '0;
			last_q       <= 1'b0;
			cls_q        <= TK_LETTER;
			prio_q       <= '0;
			count_q      <= '0;
			top_q        <= '0;
			top_ram_q    <= 1'b0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_char_q  <= '0;
			out_valid_q  <= 1'b0;
			out_char_q   <= '0;
			out_last_q   <= 1'b0;
			out_end_q    <= 1'b0;
			out_ovf_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (s_tvalid && s_tready) begin
				tok_q  <= s_tdata;
				last_q <= s_tlast;
				cls_q  <= classify(s_tdata);
				prio_q <= prio_of(s_tdata);
			end

			// stack pointer and top cache
			if (push_en) begin
				count_q <= count_q + CW'(1);
			end else if (pop_en) begin
				count_q <= count_q - CW'(1);
			end
			top_ram_q <= rd_en;
			if (push_en) begin
				top_q <= tok_q;
			end else if (top_ram_q) begin
				top_q <= rd_data;
			end

			// sticky overflow, cleared once a last item is done
			if (ovf_set) begin
				ovf_q <= 1'b1;
			end else if (state_q == ST_FINISH && state_d == ST_IDLE && last_q) begin
				ovf_q <= 1'b0;
			end

			if (emit_en) begin
				pend_valid_q <= 1'b1;
				pend_char_q  <= emit_char;
			end else if (fin_move) begin
				pend_valid_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_char_q  <= pend_char_q;
				out_last_q  <= fin_move;
				out_end_q   <= fin_move && last_q;
				out_ovf_q   <= ovf_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ovf_q, out_end_q};

	`IPC_ASSERT(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH), "stack count past depth")
	`IPC_ASSERT(a_pop_nonempty, pop_en, nonempty, "pop on empty stack")
	`IPC_ASSERT(a_idle_drained, state_q == ST_IDLE, !pend_valid_q, "held result left over")
	`IPC_ASSERT(a_load_slot, out_load, out_free, "output register overwritten")
	`IPC_ASSERT_NEXT(a_ovf_clear, state_q == ST_FINISH && state_d == ST_IDLE && last_q, !ovf_q, "overflow not cleared")

endmodule
